/* sv/u8esc_pkg.sv */
// ----------------------------------------------------------------------------
// u8esc_pkg: shared types and constants of the UTF-8 decoder
// Holds the result bundle that the decode stage passes to the output queue,
// and the widths and limits that both sides depend on.
// ----------------------------------------------------------------------------
package u8esc_pkg;

  localparam int RUNE_W  = 31;
  localparam int RES_MAX = 4;
  localparam int Q_DEPTH = 8;

  // Escape mark ORed onto a raw byte that could not be decoded
  localparam logic [RUNE_W-1:0] ESC_MARK = 31'h7000_0000;

  // Results caused by one input byte, lowest index delivered first
  typedef struct packed {
    logic [2:0]                        count;
    logic                              done;
    logic [RES_MAX-1:0][RUNE_W-1:0]    runes;
  } res_t;

endpackage

/* sv/u8esc_decode.sv */
// ----------------------------------------------------------------------------
// u8esc_decode: sequence buffer and decode for one byte per cycle while take is high
// Holds the lead and continuation bytes of an open sequence and, on the byte
// that closes it, checks the whole sequence and yields a code point or the
// escaped bytes. All results of a byte are worked out in the same cycle.
// ----------------------------------------------------------------------------
module u8esc_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        byte_in,
  input  logic              stream_end,
  output u8esc_pkg::res_t   res
);

  logic [7:0] held_bytes [3];
  logic [7:0] held_bytes_next [3];
  logic [1:0] held_count, held_count_next;
  logic [2:0] expected_len, expected_len_next;

  logic       idle;
  logic [2:0] lead_len;
  logic [2:0] cnt;
  logic [7:0] seq [4];
  logic [u8esc_pkg::RES_MAX-1:0][u8esc_pkg::RUNE_W-1:0] esc_runes;
  logic       cont1, cont2, cont3;
  logic [10:0] v2;
  logic [15:0] v3;
  logic [20:0] v4;
  logic        ok;
  logic [u8esc_pkg::RUNE_W-1:0] code;

  // Classify a byte as a sequence lead
  always_comb begin
    unique case (byte_in) inside
      [8'h00:8'h7f]: lead_len = 3'd1;
      [8'hc0:8'hdf]: lead_len = 3'd2;
      [8'he0:8'hef]: lead_len = 3'd3;
      [8'hf0:8'hf7]: lead_len = 3'd4;
      default:       lead_len = 3'd0;
    endcase
  end

  assign idle = (expected_len < 3'd2) || (expected_len > 3'd4) || (held_count == 2'd0);
  assign cnt  = {1'b0, held_count} + 3'd1;

  // Assemble the held bytes with the current one behind them
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < int'(held_count)) begin
        seq[i] = held_bytes[i];
      end else if (i == int'(held_count)) begin
        seq[i] = byte_in;
      end else begin
        seq[i] = 8'h00;
      end
      esc_runes[i] = u8esc_pkg::ESC_MARK | {23'd0, seq[i]};
    end
  end

  // Check continuation bytes and value range of the completed sequence
  assign cont1 = (seq[1][7:6] == 2'b10);
  assign cont2 = (seq[2][7:6] == 2'b10);
  assign cont3 = (seq[3][7:6] == 2'b10);
  assign v2 = {seq[0][4:0], seq[1][5:0]};
  assign v3 = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
  assign v4 = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};

  always_comb begin
    unique case (expected_len)
      3'd2: begin
        ok   = cont1 && (v2 >= 11'h080);
        code = {20'd0, v2};
      end
      3'd3: begin
        ok   = cont1 && cont2 && (v3 >= 16'h0800) &&
               !((v3 > 16'hd7ff) && (v3 < 16'he000));
        code = {15'd0, v3};
      end
      3'd4: begin
        ok   = cont1 && cont2 && cont3 && (v4 > 21'h00ffff) && (v4 <= 21'h10ffff);
        code = {10'd0, v4};
      end
      default: begin
        ok   = 1'b0;
        code = '0;
      end
    endcase
  end

  // Produce results and the next buffer state
  always_comb begin
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    expected_len_next = expected_len;
    res.count = 3'd0;
    res.done  = stream_end;
    res.runes = esc_runes;
    if (idle) begin
      if (lead_len == 3'd1) begin
        res.count    = 3'd1;
        res.runes[0] = {23'd0, byte_in};
      end else if ((lead_len == 3'd0) || stream_end) begin
        res.count    = 3'd1;
        res.runes[0] = u8esc_pkg::ESC_MARK | {23'd0, byte_in};
      end else begin
        held_bytes_next[0] = byte_in;
        held_count_next    = 2'd1;
        expected_len_next  = lead_len;
      end
      if ((lead_len < 3'd2) || stream_end) begin
        held_count_next   = 2'd0;
        expected_len_next = 3'd0;
      end
    end else if (cnt >= expected_len) begin
      if (ok) begin
        res.count    = 3'd1;
        res.runes[0] = code;
      end else begin
        res.count = expected_len;
      end
      held_count_next   = 2'd0;
      expected_len_next = 3'd0;
    end else if (stream_end) begin
      res.count         = cnt;
      held_count_next   = 2'd0;
      expected_len_next = 3'd0;
    end else begin
      held_bytes_next[held_count] = byte_in;
      held_count_next             = cnt[1:0];
    end
  end

  // Update the sequence buffer on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      expected_len <= 3'd0;
    end else if (take) begin
      held_count   <= held_count_next;
      expected_len <= expected_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

/* sv/utf8_decoder_with_byte_escape_core.sv */
// ----------------------------------------------------------------------------
// utf8_decoder_with_byte_escape_core: UTF-8 decoder with escaped bad bytes
// Results: a byte's results enter the result queue on its transfer and are offered behind any still queued.
// Throughput: one byte per cycle while the result queue has room for four
// results (eight entries); results leave at one per cycle while m_tready is
// high, set by the single output port of the queue.
// Reset: synchronous, clears the open sequence and empties the result queue.
// ----------------------------------------------------------------------------
module utf8_decoder_with_byte_escape_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] rune, [31] zero fill
  output logic        m_tlast,   // run_last
  output logic        m_tuser    // [0] stream_done
);

  localparam int CW = $clog2(u8esc_pkg::Q_DEPTH + 1);
  localparam int IW = $clog2(u8esc_pkg::Q_DEPTH);

  u8esc_pkg::res_t res;

  logic                          take;
  logic                          pop;
  logic [2:0]                    nres;
  logic [CW-1:0]                 cnt, cnt_next, cnt_base;
  logic [u8esc_pkg::RUNE_W-1:0]  q_rune [u8esc_pkg::Q_DEPTH];
  logic                          q_last [u8esc_pkg::Q_DEPTH];
  logic                          q_done [u8esc_pkg::Q_DEPTH];
  logic [u8esc_pkg::RUNE_W-1:0]  q_rune_next [u8esc_pkg::Q_DEPTH];
  logic                          q_last_next [u8esc_pkg::Q_DEPTH];
  logic                          q_done_next [u8esc_pkg::Q_DEPTH];

  assign s_tready = (cnt <= CW'(u8esc_pkg::Q_DEPTH - u8esc_pkg::RES_MAX));
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = (cnt != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {1'b0, q_rune[0]};
  assign m_tlast  = q_last[0];
  assign m_tuser  = q_done[0];

  u8esc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_in    (s_tdata),
    .stream_end (s_tlast),
    .res        (res)
  );

  assign nres     = take ? res.count : 3'd0;
  assign cnt_base = cnt - CW'(pop);
  assign cnt_next = cnt_base + CW'(nres);

  // Advance the queue by the popped entry and append the new results
  always_comb begin
    logic [CW-1:0] k;
    for (int j = 0; j < u8esc_pkg::Q_DEPTH; j++) begin
      k = CW'(j) - cnt_base;
      q_rune_next[j] = q_rune[j];
      q_last_next[j] = q_last[j];
      q_done_next[j] = q_done[j];
      if (CW'(j) < cnt_base) begin
        q_rune_next[j] = q_rune[IW'(j + int'(pop))];
        q_last_next[j] = q_last[IW'(j + int'(pop))];
        q_done_next[j] = q_done[IW'(j + int'(pop))];
      end else if (k < CW'(nres)) begin
        q_rune_next[j] = res.runes[k[1:0]];
        q_last_next[j] = (k == CW'(nres) - CW'(1));
        q_done_next[j] = (k == CW'(nres) - CW'(1)) && res.done;
      end
    end
  end

  // Hold the queue fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q_rune <= q_rune_next;
    q_last <= q_last_next;
    q_done <= q_done_next;
  end

endmodule
